/* design/adam_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the Adam update block.
package adam_pkg;

   localparam int ROWS = 64;
   localparam int COLS = 64;
   localparam int DEPTH = ROWS * COLS + ROWS;
   localparam int IDX_W = $clog2(DEPTH);

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam logic [23:0] STEP_SIZE_RESET = 24'd16777;
   localparam logic [15:0] FIRST_DECAY_RESET = 16'd58982;
   localparam logic [15:0] SECOND_DECAY_RESET = 16'd65470;
   localparam logic [24:0] STABILIZER_RESET = 25'd1;

   typedef enum logic [1:0] {
      CSR_STEP_SIZE,
      CSR_FIRST_DECAY,
      CSR_SECOND_DECAY,
      CSR_STABILIZER
   } csr_index_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_PROD,
      S_GRAD,
      S_MOM1,
      S_MOM2,
      S_MOM3,
      S_WRITE,
      S_DIV1,
      S_DIV1W,
      S_DIV2,
      S_DIV2W,
      S_SQRT,
      S_SQRTW,
      S_DIV3,
      S_DIV3W,
      S_MUL1,
      S_MUL2,
      S_OUT
   } step_type;

   typedef struct packed {
      step_type step;
      logic     accept;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic run_math;
      logic div_done;
      logic sqrt_done;
   } status_type;

endpackage

/* design/adam_optimizer_update.sv */
// Top level of the Adam optimizer update block.
// After reset the block sweeps both moment memories to zero, one entry a cycle, and takes no
// beat until the sweep is done. It then works on one item at a time: an item whose update is
// zero (no call started yet, or index out of range) skips the divider and square root; a full
// update uses the shared divider three times at one quotient bit per cycle, and the square
// root unit once at one root bit per cycle. A finished result waits in the output register
// while the next beat is taken in; a second result stalls until that register is read.
module adam_optimizer_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [24:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_out_grad,
   input  logic signed [31:0] req_in_value,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic               req_is_bias,
   input  logic               req_starts_call,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_update,
   output logic [5:0]         rsp_row_out,
   output logic [5:0]         rsp_col_out,
   output logic               rsp_bias_out
);
   import adam_pkg::*;

   cmd_type    cmd;
   status_type status;

   adam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adam_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_out_grad    (req_out_grad),
      .req_in_value    (req_in_value),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_is_bias     (req_is_bias),
      .req_starts_call (req_starts_call),
      .rsp_update      (rsp_update),
      .rsp_row_out     (rsp_row_out),
      .rsp_col_out     (rsp_col_out),
      .rsp_bias_out    (rsp_bias_out)
   );

endmodule

/* design/adam_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module adam_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [28:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);
   import adam_pkg::*;

   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [28:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [28:0] dvs_ff, dvs_in;
   logic [29:0] trial;
   logic        fits;

   always_comb begin
      trial = {rem_ff, quo_ff[63]};
      fits = trial >= {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = '0;
         busy_in = 1'b1;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 29'(trial - {1'b0, dvs_ff}) : trial[28:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

/* design/adam_sqrt.sv */
// Digit-by-digit integer square root that settles one root bit per cycle.
module adam_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   import adam_pkg::*;

   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] rad_ff, rad_in;
   logic [35:0] shifted;
   logic [35:0] trial;
   logic        fits;

   always_comb begin
      shifted = {rem_ff[33:0], rad_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      fits = shifted >= trial;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      root_in = root_ff;
      rad_in = rad_ff;
      if (start) begin
         cnt_in = '0;
         busy_in = 1'b1;
         rem_in = '0;
         root_in = '0;
         rad_in = radicand;
      end else if (busy_ff) begin
         rem_in = fits ? shifted - trial : shifted;
         root_in = {root_ff[30:0], fits};
         rad_in = {rad_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      rad_ff <= rad_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* design/adam_ctrl.sv */
// Controller state machine that sequences the Adam datapath and owns the handshakes.
module adam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  adam_pkg::status_type status,
   output adam_pkg::cmd_type    cmd
);
   import adam_pkg::*;

   step_type state_ff, state_in;
   logic     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.step = state_ff;
      cmd.accept = 1'b0;
      cmd.rsp_load = 1'b0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ:  state_in = S_PROD;
         S_PROD:  state_in = S_GRAD;
         S_GRAD:  state_in = S_MOM1;
         S_MOM1:  state_in = S_MOM2;
         S_MOM2:  state_in = S_MOM3;
         S_MOM3:  state_in = S_WRITE;
         S_WRITE: state_in = status.run_math ? S_DIV1 : S_OUT;
         S_DIV1:  state_in = S_DIV1W;
         S_DIV1W: begin
            if (status.div_done) state_in = S_DIV2;
         end
         S_DIV2:  state_in = S_DIV2W;
         S_DIV2W: begin
            if (status.div_done) state_in = S_SQRT;
         end
         S_SQRT:  state_in = S_SQRTW;
         S_SQRTW: begin
            if (status.sqrt_done) state_in = S_DIV3;
         end
         S_DIV3:  state_in = S_DIV3W;
         S_DIV3W: begin
            if (status.div_done) state_in = S_MUL1;
         end
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/adam_dp.sv */
// Datapath with registers, moment memories, multipliers, divider and square root.
module adam_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  adam_pkg::cmd_type     cmd,
   output adam_pkg::status_type  status,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [24:0]          csr_wdata,
   input  logic signed [31:0]   req_out_grad,
   input  logic signed [31:0]   req_in_value,
   input  logic [5:0]           req_row,
   input  logic [5:0]           req_col,
   input  logic                 req_is_bias,
   input  logic                 req_starts_call,
   output logic signed [31:0]   rsp_update,
   output logic [5:0]           rsp_row_out,
   output logic [5:0]           rsp_col_out,
   output logic                 rsp_bias_out
);
   import adam_pkg::*;

   localparam logic [IDX_W-1:0] BIAS_BASE = IDX_W'(ROWS * COLS);

   logic [23:0] lr_ff;
   logic [15:0] fd_ff;
   logic [15:0] sd_ff;
   logic [24:0] eps_ff;
   logic [16:0] p1_ff;
   logic [16:0] p2_ff;
   logic [IDX_W-1:0] clr_ff;

   logic signed [31:0] og_ff;
   logic signed [31:0] iv_ff;
   logic [5:0]         row_ff;
   logic [5:0]         col_ff;
   logic               bias_ff;
   logic               start_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;

   logic [31:0]        m_mem [DEPTH];
   logic [31:0]        v_mem [DEPTH];
   logic signed [31:0] m_rd_ff;
   logic [31:0]        v_rd_ff;

   logic signed [63:0] prod_ff;
   logic signed [31:0] g_ff;
   logic signed [50:0] ma_ff;
   logic [63:0]        gg_ff;
   logic [31:0]        sq_ff;
   logic [47:0]        va_ff;
   logic               neg_ff;
   logic [31:0]        mag_ff;
   logic [47:0]        mhat_ff;
   logic [48:0]        vhat_ff;
   logic [28:0]        s_ff;
   logic [63:0]        q_ff;
   logic [55:0]        ph_ff;
   logic               big_ff;
   logic [56:0]        res_ff;

   logic signed [63:0] prod_w;
   logic signed [39:0] psh;
   logic signed [31:0] gsat;
   logic [16:0]        cf;
   logic [16:0]        cs;
   logic signed [48:0] fdm;
   logic signed [49:0] fdg;
   logic signed [63:0] gg_w;
   logic [47:0]        sdv;
   logic [48:0]        sdq;
   logic [32:0]        p1_prod;
   logic [32:0]        p2_prod;
   logic [31:0]        m_new;
   logic [31:0]        v_new;
   logic [24:0]        eps_eff;
   logic [32:0]        vs;
   logic [16:0]        c1;
   logic [16:0]        c2;
   logic [47:0]        pl;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [31:0]        wr_m;
   logic [31:0]        wr_v;
   logic               div_start;
   logic [63:0]        div_dividend;
   logic [28:0]        div_divisor;
   logic [63:0]        div_quo;
   logic               div_done;
   logic               sqrt_start;
   logic [31:0]        sqrt_root;
   logic               sqrt_done;
   logic signed [31:0] upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= STEP_SIZE_RESET;
         fd_ff <= FIRST_DECAY_RESET;
         sd_ff <= SECOND_DECAY_RESET;
         eps_ff <= STABILIZER_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_SIZE:     lr_ff <= csr_wdata[23:0];
            CSR_FIRST_DECAY:   fd_ff <= csr_wdata[15:0];
            CSR_SECOND_DECAY:  sd_ff <= csr_wdata[15:0];
            CSR_STABILIZER:    eps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      p1_prod = 33'(p1_ff) * 33'(fd_ff);
      p2_prod = 33'(p2_ff) * 33'(sd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= ONE_Q16;
         p2_ff <= ONE_Q16;
         clr_ff <= '0;
      end else begin
         if (cmd.step == S_PROD && start_ff) p1_ff <= p1_prod[32:16];
         if (cmd.step == S_GRAD && start_ff) p2_ff <= p2_prod[32:16];
         if (cmd.step == S_CLEAR) clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   always_comb begin
      valid_in = (11'(req_row) < 11'(ROWS)) && (req_is_bias || (11'(req_col) < 11'(COLS)));
      if (req_is_bias) idx_in = BIAS_BASE + IDX_W'(req_row);
      else idx_in = IDX_W'(req_row) * IDX_W'(COLS) + IDX_W'(req_col);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         og_ff <= req_out_grad;
         iv_ff <= req_in_value;
         row_ff <= req_row;
         col_ff <= req_col;
         bias_ff <= req_is_bias;
         start_ff <= req_starts_call;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      prod_w = og_ff * iv_ff;
      psh = prod_ff[63:24];
      if (psh[39:31] == {9{psh[39]}}) gsat = psh[31:0];
      else if (psh[39]) gsat = 32'sh8000_0000;
      else gsat = 32'sh7FFF_FFFF;
      cf = ONE_Q16 - 17'(fd_ff);
      cs = ONE_Q16 - 17'(sd_ff);
      fdm = $signed({1'b0, fd_ff}) * m_rd_ff;
      fdg = $signed({1'b0, cf}) * g_ff;
      gg_w = g_ff * g_ff;
      sdv = 48'(sd_ff) * 48'(v_rd_ff);
      sdq = 49'(cs) * 49'(sq_ff);
      m_new = ma_ff[47:16];
      v_new = va_ff[47:16];
      eps_eff = (eps_ff == '0) ? 25'd1 : eps_ff;
      vs = 33'(v_new) + 33'(eps_eff);
      c1 = ONE_Q16 - p1_ff;
      c2 = ONE_Q16 - p2_ff;
      pl = 48'(q_ff[23:0]) * 48'(lr_ff);
   end

   always_ff @(posedge clock) begin
      case (cmd.step)
         S_PROD: prod_ff <= prod_w;
         S_GRAD: g_ff <= bias_ff ? og_ff : gsat;
         S_MOM1: begin
            ma_ff <= 51'(fdm);
            gg_ff <= gg_w;
            va_ff <= sdv;
         end
         S_MOM2: begin
            ma_ff <= ma_ff + 51'(fdg);
            sq_ff <= (gg_ff[63:56] != '0) ? '1 : gg_ff[55:24];
         end
         S_MOM3: va_ff <= va_ff + sdq[47:0];
         S_WRITE: begin
            neg_ff <= m_new[31];
            mag_ff <= m_new[31] ? 32'(-m_new) : m_new;
         end
         S_DIV1W: if (div_done) mhat_ff <= div_quo[47:0];
         S_DIV2W: if (div_done) vhat_ff <= div_quo[48:0];
         S_SQRTW: begin
            if (sqrt_done) s_ff <= (sqrt_root == '0) ? 29'd1 : sqrt_root[28:0];
         end
         S_DIV3W: if (div_done) q_ff <= div_quo;
         S_MUL1: begin
            ph_ff <= 56'(q_ff[55:24]) * 56'(lr_ff);
            big_ff <= (q_ff[63:56] != '0) && (lr_ff != '0);
         end
         S_MUL2: res_ff <= 57'(ph_ff) + 57'(pl[47:24]);
         default: ;
      endcase
   end

   always_comb begin
      wr_en = (cmd.step == S_CLEAR) || (cmd.step == S_WRITE && valid_ff);
      wr_addr = (cmd.step == S_CLEAR) ? clr_ff : idx_ff;
      wr_m = (cmd.step == S_CLEAR) ? '0 : m_new;
      wr_v = (cmd.step == S_CLEAR) ? '0 : v_new;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         m_mem[wr_addr] <= wr_m;
         v_mem[wr_addr] <= wr_v;
      end
      if (cmd.step == S_READ) begin
         m_rd_ff <= m_mem[idx_ff];
         v_rd_ff <= v_mem[idx_ff];
      end
   end

   always_comb begin
      div_start = (cmd.step == S_DIV1) || (cmd.step == S_DIV2) || (cmd.step == S_DIV3);
      case (cmd.step)
         S_DIV1: begin
            div_dividend = 64'({mag_ff, 16'h0000});
            div_divisor = 29'(c1);
         end
         S_DIV2: begin
            div_dividend = 64'({vs, 16'h0000});
            div_divisor = 29'(c2);
         end
         default: begin
            div_dividend = {mhat_ff, 16'h0000};
            div_divisor = s_ff;
         end
      endcase
      sqrt_start = cmd.step == S_SQRT;
   end

   adam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   adam_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (64'({vhat_ff, 8'h00})),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   always_comb begin
      if (!status.run_math) upd = '0;
      else if (neg_ff) begin
         upd = (big_ff || res_ff > 57'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(res_ff[31:0]);
      end else begin
         upd = (big_ff || res_ff > 57'h8000_0000) ? 32'sh8000_0000
                                                  : $signed(32'(-res_ff[31:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_update <= upd;
         rsp_row_out <= row_ff;
         rsp_col_out <= bias_ff ? 6'd0 : col_ff;
         rsp_bias_out <= bias_ff;
      end
   end

   assign status.clear_last = clr_ff == IDX_W'(DEPTH - 1);
   assign status.run_math = valid_ff && !p1_ff[16] && !p2_ff[16];
   assign status.div_done = div_done;
   assign status.sqrt_done = sqrt_done;

endmodule

/* design/adam_checker.sv */
// Port-level checks of the Adam update block and their binding to the top level.
module adam_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_update,
   input logic [5:0]         rsp_col_out,
   input logic               rsp_bias_out
);
   import adam_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_update))
      else $error("result beat changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input taken before the memories were cleared");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while an item is in progress");

   a_bias_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bias_out |-> rsp_col_out == 6'd0)
      else $error("bias result carries a column");

endmodule

bind adam_optimizer_update adam_checker u_adam_checker (.*);

/* bench/tb_adam_optimizer_update.sv */
// Self-checking testbench for the Adam optimizer update block with a fixed-point scoreboard.
import adam_pkg::*;

typedef struct {
   logic signed [31:0] out_grad;
   logic signed [31:0] in_value;
   logic [5:0]         row;
   logic [5:0]         col;
   logic               is_bias;
   logic               starts_call;
} grad_item;

typedef struct {
   logic [31:0] update;
   logic [5:0]  row;
   logic [5:0]  col;
   logic        bias;
} update_beat;

class update_scoreboard;
   logic [23:0] step_size;
   logic [15:0] first_decay;
   logic [15:0] second_decay;
   logic [24:0] stabilizer;
   logic [31:0] first_moment [DEPTH];
   logic [31:0] second_moment [DEPTH];
   longint unsigned first_power;
   longint unsigned second_power;
   update_beat expected_updates [$];
   int errors;
   int items_seen;
   int results_checked;
   int nonzero_updates;

   function new();
      step_size = STEP_SIZE_RESET;
      first_decay = FIRST_DECAY_RESET;
      second_decay = SECOND_DECAY_RESET;
      stabilizer = STABILIZER_RESET;
      foreach (first_moment[i]) begin
         first_moment[i] = '0;
         second_moment[i] = '0;
      end
      first_power = 65536;
      second_power = 65536;
      errors = 0;
      items_seen = 0;
      results_checked = 0;
      nonzero_updates = 0;
   endfunction

   function void set_reg(csr_index_type index, logic [24:0] value);
      case (index)
         CSR_STEP_SIZE: step_size = value[23:0];
         CSR_FIRST_DECAY: first_decay = value[15:0];
         CSR_SECOND_DECAY: second_decay = value[15:0];
         CSR_STABILIZER: stabilizer = value;
         default: ;
      endcase
   endfunction

   function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function int pending();
      return expected_updates.size();
   endfunction

   function void note_input(grad_item it);
      longint grad;
      longint moment;
      longint fd;
      longint unsigned sq;
      longint unsigned vm;
      longint unsigned mag;
      longint unsigned c1;
      longint unsigned c2;
      longint unsigned eps;
      longint unsigned mhat;
      longint unsigned vhat;
      longint unsigned root;
      longint unsigned quot;
      longint unsigned res;
      longint upd;
      int idx;
      bit in_range;
      bit neg_m;
      update_beat beat;
      in_range = (it.row < ROWS) && (it.is_bias || it.col < COLS);
      idx = it.is_bias ? ROWS * COLS + it.row : it.row * COLS + it.col;
      upd = 0;
      items_seen++;
      if (in_range) begin
         if (it.is_bias) begin
            grad = it.out_grad;
         end else begin
            grad = (longint'(it.out_grad) * longint'(it.in_value)) >>> 24;
            if (grad > 64'sd2147483647) grad = 64'sd2147483647;
            if (grad < -64'sd2147483648) grad = -64'sd2147483648;
         end
         moment = longint'(signed'(first_moment[idx]));
         sq = longint'(grad * grad) >> 24;
         if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
         fd = first_decay;
         moment = (fd * moment + (65536 - fd) * grad) >>> 16;
         vm = second_moment[idx];
         vm = (longint'(second_decay) * vm + (65536 - longint'(second_decay)) * sq) >> 16;
         first_moment[idx] = moment[31:0];
         second_moment[idx] = vm[31:0];
      end
      if (it.starts_call) begin
         first_power = (first_power * first_decay) >> 16;
         second_power = (second_power * second_decay) >> 16;
      end
      if (in_range && first_power < 65536 && second_power < 65536) begin
         moment = longint'(signed'(first_moment[idx]));
         neg_m = moment < 0;
         mag = neg_m ? -moment : moment;
         c1 = 65536 - first_power;
         c2 = 65536 - second_power;
         eps = (stabilizer == 0) ? 1 : stabilizer;
         mhat = (mag << 16) / c1;
         vhat = ((longint'(second_moment[idx]) + eps) << 16) / c2;
         root = int_sqrt(vhat << 8);
         if (root == 0) root = 1;
         quot = (mhat << 16) / root;
         res = (quot >> 24) * step_size + (((quot & 64'hFF_FFFF) * step_size) >> 24);
         if (neg_m) upd = (res > 64'd2147483647) ? 64'sd2147483647 : res;
         else upd = (res > 64'd2147483648) ? -64'sd2147483648 : -longint'(res);
      end
      beat.update = upd[31:0];
      beat.row = it.row;
      beat.col = it.is_bias ? 6'd0 : it.col;
      beat.bias = it.is_bias;
      expected_updates.push_back(beat);
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_result(update_beat got);
      update_beat want;
      if (expected_updates.size() == 0) begin
         report_mismatch("unexpected beat", got.update, 0);
         return;
      end
      want = expected_updates.pop_front();
      results_checked++;
      if (want.update != 0) nonzero_updates++;
      if (got.update !== want.update) report_mismatch("update", got.update, want.update);
      if (got.row !== want.row) report_mismatch("row_out", got.row, want.row);
      if (got.col !== want.col) report_mismatch("col_out", got.col, want.col);
      if (got.bias !== want.bias) report_mismatch("bias_out", got.bias, want.bias);
   endtask
endclass

module tb_adam_optimizer_update;
   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [24:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_out_grad;
   logic signed [31:0] req_in_value;
   logic [5:0]         req_row;
   logic [5:0]         req_col;
   logic               req_is_bias;
   logic               req_starts_call;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_update;
   logic [5:0]         rsp_row_out;
   logic [5:0]         rsp_col_out;
   logic               rsp_bias_out;

   update_scoreboard book = new();
   bit hold_output = 0;
   bit steady_output = 0;

   adam_optimizer_update dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #16000000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      update_beat got;
      if (!reset && req_valid && req_ready) begin
         book.note_input('{req_out_grad, req_in_value, req_row, req_col, req_is_bias,
                           req_starts_call});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.update = rsp_update;
         got.row = rsp_row_out;
         got.col = rsp_col_out;
         got.bias = rsp_bias_out;
         book.check_result(got);
      end
   end

   initial begin
      int stall_left;
      int pick;
      stall_left = 0;
      rsp_ready <= 0;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_ready <= 0;
            repeat (1500) @(posedge clock);
            hold_output = 0;
         end else if (steady_output) begin
            rsp_ready <= 1;
         end else if (stall_left > 0) begin
            rsp_ready <= 0;
            stall_left--;
         end else begin
            rsp_ready <= 1;
            pick = $urandom_range(0, 99);
            if (pick < 20) stall_left = $urandom_range(1, 4);
            else if (pick < 23) stall_left = $urandom_range(30, 300);
         end
      end
   end

   task write_reg(csr_index_type index, logic [24:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      book.set_reg(index, value);
      @(posedge clock);
   endtask

   task send_item(grad_item it, bit keep_valid);
      req_valid <= 1;
      req_out_grad <= it.out_grad;
      req_in_value <= it.in_value;
      req_row <= it.row;
      req_col <= it.col;
      req_is_bias <= it.is_bias;
      req_starts_call <= it.starts_call;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!keep_valid) req_valid <= 0;
   endtask

   task drain();
      while (book.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         3: return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function grad_item random_item();
      grad_item it;
      it.out_grad = pick_value();
      it.in_value = pick_value();
      it.row = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 3));
      it.col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 3));
      it.is_bias = $urandom_range(0, 5) == 0;
      it.starts_call = $urandom_range(0, 7) == 0;
      return it;
   endfunction

   initial begin
      grad_item directed [$];
      grad_item it;
      logic [23:0] rates [6];
      logic [15:0] decays1 [6];
      logic [15:0] decays2 [6];
      logic [24:0] epsilons [6];
      int gap;
      reset <= 1;
      csr_we <= 0;
      csr_index <= CSR_STEP_SIZE;
      csr_wdata <= '0;
      req_valid <= 0;
      req_out_grad <= '0;
      req_in_value <= '0;
      req_row <= '0;
      req_col <= '0;
      req_is_bias <= 0;
      req_starts_call <= 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Before the first call both powers are one, so the four items ahead of it get zero updates.
      directed.push_back('{32'sh0100_0000, 32'sh0100_0000, 6'd0, 6'd0, 1'b0, 1'b0});
      directed.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 6'd63, 6'd63, 1'b0, 1'b0});
      directed.push_back('{-32'sh8000_0000, 32'sh7FFF_FFFF, 6'd1, 6'd2, 1'b0, 1'b0});
      directed.push_back('{32'sh0080_0000, 32'sh0, 6'd5, 6'd9, 1'b1, 1'b0});
      directed.push_back('{32'sh0100_0000, 32'sh0200_0000, 6'd0, 6'd0, 1'b0, 1'b1});
      directed.push_back('{-32'sh0100_0000, 32'sh0200_0000, 6'd0, 6'd0, 1'b0, 1'b0});
      directed.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 6'd63, 6'd63, 1'b0, 1'b0});
      directed.push_back('{-32'sh8000_0000, -32'sh8000_0000, 6'd62, 6'd0, 1'b0, 1'b0});
      directed.push_back('{-32'sh8000_0000, 32'sh7FFF_FFFF, 6'd1, 6'd2, 1'b0, 1'b1});
      directed.push_back('{32'sh7FFF_FFFF, 32'sh0, 6'd63, 6'd17, 1'b1, 1'b0});
      directed.push_back('{-32'sh8000_0000, 32'sh0, 6'd0, 6'd63, 1'b1, 1'b0});
      directed.push_back('{32'sh0, 32'sh0, 6'd7, 6'd7, 1'b0, 1'b0});
      directed.push_back('{32'sh1, -32'sh1, 6'd8, 6'd8, 1'b0, 1'b1});
      directed.push_back('{32'sh0000_0001, 32'sh0, 6'd9, 6'd0, 1'b1, 1'b0});
      directed.push_back('{32'sh5555_5555, -32'sh5555_5556, 6'd42, 6'd21, 1'b0, 1'b0});
      directed.push_back('{-32'sh5555_5556, 32'sh5555_5555, 6'd21, 6'd42, 1'b0, 1'b1});
      foreach (directed[i]) send_item(directed[i], i < directed.size() - 1);
      drain();

      rates = '{24'd16777, 24'hFF_FFFF, 24'd0, 24'd1_000_000, 24'd1, 24'd0};
      decays1 = '{16'd58982, 16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd0};
      decays2 = '{16'd65470, 16'd0, 16'hFFFF, 16'd60000, 16'hFFFF, 16'd0};
      epsilons = '{25'd1, 25'd0, 25'h100_0000, 25'd1000, 25'd1, 25'd0};
      rates[5] = 24'($urandom);
      decays1[5] = 16'($urandom);
      decays2[5] = 16'($urandom);
      epsilons[5] = 25'($urandom_range(1, 25'h100_0000));

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_STEP_SIZE, {1'b1, rates[phase]});
         write_reg(CSR_FIRST_DECAY, {9'h1FF, decays1[phase]});
         write_reg(CSR_SECOND_DECAY, {9'h0AA, decays2[phase]});
         write_reg(CSR_STABILIZER, epsilons[phase]);
         if (phase == 1) hold_output = 1;
         steady_output = (phase == 3);
         for (int n = 0; n < 140; n++) begin
            it = random_item();
            gap = $urandom_range(0, 99);
            if (phase == 1 || n < 15) gap = 0;
            else if (gap < 50) gap = 0;
            else if (gap < 90) gap = $urandom_range(1, 4);
            else gap = $urandom_range(20, 300);
            send_item(it, gap == 0 && n < 139);
            repeat (gap) @(posedge clock);
         end
         steady_output = 0;
         drain();
      end

      $display("Covered %0d items and %0d checked updates (%0d nonzero) across six settings.",
               book.items_seen, book.results_checked, book.nonzero_updates);
      $display("Included extreme rates, decays and epsilons, a long output stall and idle drains.");
      if (book.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* adam_optimizer_update.f */
design/adam_pkg.sv
design/adam_div.sv
design/adam_sqrt.sv
design/adam_ctrl.sv
design/adam_dp.sv
design/adam_optimizer_update.sv
design/adam_checker.sv
bench/tb_adam_optimizer_update.sv
